>>> rtl/ttpq_pkg.sv
package ttpq_pkg;

	localparam int unsigned CountW = 14;
	localparam int unsigned TicksW = 11;
	localparam int unsigned ModeW  = 2;
	localparam int unsigned PhaseW = 2;

	// saturation point of the tick count, longest accepted pulse, idle run needed
	localparam logic [CountW-1:0] COUNT_MAX  = CountW'(9999);
	localparam logic [CountW-1:0] ACCEPT_MAX = CountW'(2020);
	localparam logic [CountW-1:0] IDLE_NEED  = CountW'(10);

	// phase codes
	localparam logic [PhaseW-1:0] PH_WAIT   = 2'd0;
	localparam logic [PhaseW-1:0] PH_HOLD   = 2'd1;
	localparam logic [PhaseW-1:0] PH_RETURN = 2'd2;

	// mode codes
	localparam logic [ModeW-1:0] MODE_OFF  = 2'd0;
	localparam logic [ModeW-1:0] MODE_HIGH = 2'd1;
	localparam logic [ModeW-1:0] MODE_LOW  = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_MIN_ACT = 1'b1;

	localparam logic [ModeW-1:0]  MODE_RESET    = MODE_HIGH;
	localparam logic [CountW-1:0] MIN_ACT_RESET = CountW'(50);

	// increment with saturation
	function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
		logic [CountW-1:0] r;
		if (c >= COUNT_MAX - CountW'(1)) r = COUNT_MAX;
		else r = c + CountW'(1);
		return r;
	endfunction

endpackage

>>> rtl/ttl_trigger_pulse_qualifier_top.sv
// ttl trigger pulse qualifier
// one input transaction on the s_axis side carries one sample of the trigger line
// (one sample per millisecond tick). every sample yields exactly one output
// transaction on the m_axis side with the trigger flag, the qualified pulse
// length and the qualifier phase after that sample.
// the apb port sets the mode (0 frozen, 1 active high, 2 active low) at address 0
// and the minimum active hold in ticks at address 4; write them while no sample
// is in flight.
// a sample is held in the input register, then its result in the result register,
// which drives m_axis (two register stages: input register, result register).
// throughput: one sample per cycle unless m_axis stalls; the state update is one
// saturating increment and a compare between the input and result registers.
// when the receiver stalls, the result register holds its transaction; one more
// sample is taken into the input register, then s_axis_tready drops until the
// result is taken.
// reset clears the qualifier state (phase waiting idle, count zero), sets mode 1
// and a minimum hold of 50 ticks, and empties both stages.
module ttl_trigger_pulse_qualifier_top (
	input  logic        clk,
	input  logic        arst_n,
	// sample stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] line_level, [7:1] zero
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] trigger, [11:1] pulse_ticks, [13:12] phase, [15:14] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [ttpq_pkg::ModeW-1:0]  mode_q;
	logic [ttpq_pkg::CountW-1:0] min_act_q;

	// qualifier state
	logic [ttpq_pkg::CountW-1:0] tick_count_q;
	logic [ttpq_pkg::PhaseW-1:0] phase_q;
	logic                        seen_active_q;

	// input stage
	logic valid_s1;
	logic level_s1;

	// result stage
	logic                        valid_s2;
	logic                        trig_s2;
	logic [ttpq_pkg::TicksW-1:0] ticks_s2;
	logic [ttpq_pkg::PhaseW-1:0] phase_s2;

	logic adv;
	logic fire;
	logic cfg_wr;

	// next-state logic
	logic                        active;
	logic [ttpq_pkg::CountW-1:0] base;
	logic [ttpq_pkg::CountW-1:0] bumped;
	logic [ttpq_pkg::CountW-1:0] count_d;
	logic [ttpq_pkg::PhaseW-1:0] phase_d;
	logic                        seen_d;
	logic                        trig_d;
	logic [ttpq_pkg::TicksW-1:0] ticks_d;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	// result register free or being emptied this cycle
	assign adv           = ~valid_s2 | m_axis_tready;
	assign fire          = valid_s1 & adv;
	assign s_axis_tready = ~valid_s1 | adv;

	always_comb begin
		unique case (paddr[2])
			ttpq_pkg::REG_MODE:    prdata = 32'(mode_q);
			ttpq_pkg::REG_MIN_ACT: prdata = 32'(min_act_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ttpq_pkg::MODE_RESET;
			min_act_q <= ttpq_pkg::MIN_ACT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == ttpq_pkg::REG_MODE) mode_q <= pwdata[ttpq_pkg::ModeW-1:0];
			else min_act_q <= pwdata[ttpq_pkg::CountW-1:0];
		end
	end

	// polarity: mode 1 active high, any other nonzero mode active low
	assign active = (mode_q == ttpq_pkg::MODE_HIGH) ? level_s1 : ~level_s1;

	always_comb begin
		count_d = tick_count_q;
		phase_d = phase_q;
		seen_d  = seen_active_q;
		trig_d  = 1'b0;
		ticks_d = '0;
		base    = tick_count_q;
		bumped  = ttpq_pkg::bump(tick_count_q);
		if (mode_q != ttpq_pkg::MODE_OFF) begin
			unique case (phase_q)
				ttpq_pkg::PH_WAIT: begin
					// an idle sample after any active one restarts the idle run
					if (!active) begin
						if (seen_active_q) begin
							base   = '0;
							seen_d = 1'b0;
						end
					end else begin
						seen_d = 1'b1;
					end
					bumped  = ttpq_pkg::bump(base);
					count_d = bumped;
					if (bumped == ttpq_pkg::IDLE_NEED) phase_d = ttpq_pkg::PH_HOLD;
				end
				ttpq_pkg::PH_HOLD: begin
					if (active) begin
						count_d = bumped;
						if (bumped >= min_act_q) phase_d = ttpq_pkg::PH_RETURN;
					end else begin
						count_d = '0;
					end
				end
				default: begin
					// awaiting return to idle
					if (!active) begin
						if (bumped <= ttpq_pkg::ACCEPT_MAX) begin
							trig_d  = 1'b1;
							ticks_d = bumped[ttpq_pkg::TicksW-1:0];
						end
						count_d = '0;
						phase_d = ttpq_pkg::PH_WAIT;
					end else begin
						count_d = bumped;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			tick_count_q  <= '0;
			phase_q       <= ttpq_pkg::PH_WAIT;
			seen_active_q <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (adv) valid_s2 <= valid_s1;
			if (fire) begin
				tick_count_q  <= count_d;
				phase_q       <= phase_d;
				seen_active_q <= seen_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready & s_axis_tvalid) level_s1 <= s_axis_tdata[0];
		if (fire) begin
			trig_s2  <= trig_d;
			ticks_s2 <= ticks_d;
			phase_s2 <= phase_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, phase_s2, ticks_s2, trig_s2};

	// a trigger is only raised on the return to the waiting phase
	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && trig_s2) |-> (phase_s2 == ttpq_pkg::PH_WAIT))
		else $error("trigger reported outside waiting phase");

	// pulse length is zero unless a trigger is reported
	a_ticks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !trig_s2) |-> (ticks_s2 == '0))
		else $error("pulse_ticks nonzero without trigger");

	// the count never passes its saturation point
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q <= ttpq_pkg::COUNT_MAX)
		else $error("tick count above saturation");

	// frozen mode leaves the qualifier state untouched
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_q == ttpq_pkg::MODE_OFF) |=>
		($stable(tick_count_q) && $stable(phase_q) && $stable(seen_active_q)))
		else $error("state changed while disabled");

	// a sample taken into a full input stage must not be dropped
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("input stage lost a sample");

endmodule

>>> tb/ttl_trigger_pulse_qualifier_top_tb.sv
`timescale 1ns / 1ps

module ttl_trigger_pulse_qualifier_top_tb;

	typedef logic [ttpq_pkg::CountW-1:0] count_t;

	// mode 3 is decoded like the active-low mode
	localparam logic [ttpq_pkg::ModeW-1:0] MODE_LOW_ALT = 2'd3;
	// a hold requirement above the count ceiling, never met
	localparam count_t MIN_UNREACHABLE = count_t'(16383);
	// receiver hold-off long enough to fill both stages and stall the input
	localparam int HOLD_OFF_CYCLES = 40;
	// generous limit on the whole run, in clock cycles
	localparam longint LIMIT_CYCLES = 1_500_000;

	// one result transaction: trigger flag, pulse length and phase
	typedef struct packed {
		logic                        trig;
		logic [ttpq_pkg::TicksW-1:0] ticks;
		logic [ttpq_pkg::PhaseW-1:0] phase;
	} qual_result_t;

	// directed stimulus rows: a line sample or a register write
	typedef enum logic [1:0] {ROW_SAMPLE, ROW_SET_MODE, ROW_SET_MIN} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		count_t       arg;        // line level or register value
		logic         fixed_exp;  // expected result written in the row
		qual_result_t want;
	} dir_row_t;

	localparam int N_DIR = 32;

	// directed walk, starting from the reset settings (active high, hold 50)
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// nine idle ticks stay in the waiting phase
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		// tenth tick enters the hold check
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_HOLD}},
		// zero hold is met by the first active tick
		'{ROW_SET_MIN, 14'd0, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_RETURN}},
		'{ROW_SAMPLE, 14'd0, 1'b1, '{1'b1, 11'd12, ttpq_pkg::PH_WAIT}},
		// active then idle restarts the idle count
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd0, 1'b0, '0},
		// frozen mode
		'{ROW_SET_MODE, count_t'(ttpq_pkg::MODE_OFF), 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b1, '{1'b0, 11'd0, ttpq_pkg::PH_WAIT}},
		// mode 3 acts active low
		'{ROW_SET_MODE, count_t'(MODE_LOW_ALT), 1'b0, '0},
		'{ROW_SAMPLE, 14'd0, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		// active low with a hold that can never be met
		'{ROW_SET_MODE, count_t'(ttpq_pkg::MODE_LOW), 1'b0, '0},
		'{ROW_SET_MIN, MIN_UNREACHABLE, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd1, 1'b0, '0},
		'{ROW_SAMPLE, 14'd0, 1'b0, '0}
	};

	// settings for the random phases, extremes among them
	localparam int N_RND = 6;
	localparam logic [ttpq_pkg::ModeW-1:0] RND_MODES [N_RND] =
		'{ttpq_pkg::MODE_HIGH, ttpq_pkg::MODE_LOW, ttpq_pkg::MODE_HIGH,
		  ttpq_pkg::MODE_OFF, ttpq_pkg::MODE_LOW, ttpq_pkg::MODE_HIGH};
	localparam count_t RND_MINS [N_RND] =
		'{14'd1, 14'd4, 14'd9999, 14'd7, 14'd25, 14'd2};

	// dut signals, all inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ttl_trigger_pulse_qualifier_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 12 ns period
	always #6 clk = ~clk;

	// qualifier model state and its copy of the registers
	logic [ttpq_pkg::ModeW-1:0]  q_mode = ttpq_pkg::MODE_RESET;
	count_t                      q_min_hold = ttpq_pkg::MIN_ACT_RESET;
	count_t                      q_count = '0;
	logic [ttpq_pkg::PhaseW-1:0] q_phase = ttpq_pkg::PH_WAIT;
	logic                        q_seen = 1'b0;

	// results still owed by the block, oldest first
	qual_result_t awaited_results[$];

	int fail_count = 0;
	int samples_sent = 0;
	int reg_writes = 0;
	int triggers_seen = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	// saturating tick counter step
	function automatic count_t count_step(input count_t c);
		logic [ttpq_pkg::CountW:0] n;
		n = {1'b0, c} + 1'b1;
		if (n >= {1'b0, ttpq_pkg::COUNT_MAX}) n = {1'b0, ttpq_pkg::COUNT_MAX};
		return n[ttpq_pkg::CountW-1:0];
	endfunction

	// advances the qualifier by one tick and returns the result it reports
	function automatic qual_result_t qualify_sample(input logic lvl);
		logic         act;
		qual_result_t r;
		r = '0;
		if (q_mode != ttpq_pkg::MODE_OFF) begin
			// mode 1 is active high, modes 2 and 3 active low
			act = (q_mode == ttpq_pkg::MODE_HIGH) ? lvl : ~lvl;
			case (q_phase)
				ttpq_pkg::PH_WAIT: begin
					if (!act) begin
						// an earlier active tick restarts the idle count
						if (q_seen) begin
							q_count = '0;
							q_seen = 1'b0;
						end
					end else begin
						q_seen = 1'b1;
					end
					q_count = count_step(q_count);
					if (q_count == ttpq_pkg::IDLE_NEED) q_phase = ttpq_pkg::PH_HOLD;
				end
				ttpq_pkg::PH_HOLD: begin
					q_count = count_step(q_count);
					if (act) begin
						if (q_count >= q_min_hold) q_phase = ttpq_pkg::PH_RETURN;
					end else begin
						q_count = '0;
					end
				end
				default: begin
					// awaiting return, also taken by an unused phase code
					q_count = count_step(q_count);
					if (!act) begin
						if (q_count <= ttpq_pkg::ACCEPT_MAX) begin
							r.trig = 1'b1;
							r.ticks = q_count[ttpq_pkg::TicksW-1:0];
						end
						q_count = '0;
						q_phase = ttpq_pkg::PH_WAIT;
					end
				end
			endcase
		end
		r.phase = q_phase;
		return r;
	endfunction

	// offers one line sample; a burst/gap scheme spaces the transactions
	task automatic send_sample(input logic lvl, input logic fixed_exp, input qual_result_t want);
		int           gap;
		qual_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, lvl};
		// transaction completes at the rising edge with tvalid and tready high
		do @(posedge clk); while (!s_axis_tready);
		predicted = qualify_sample(lvl);
		awaited_results.push_back(fixed_exp ? want : predicted);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic lvl, input int len);
		repeat (len) send_sample(lvl, 1'b0, '0);
	endtask

	// sender stops and waits until every owed result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// apb write followed by a read back of the same register
	task automatic write_register(input logic idx, input count_t val);
		logic [31:0] want;
		want = (idx == ttpq_pkg::REG_MODE) ? 32'(val[ttpq_pkg::ModeW-1:0]) : 32'(val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= want;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("register %0d read back: expected %0d, got %0d", idx, want, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == ttpq_pkg::REG_MODE) q_mode = val[ttpq_pkg::ModeW-1:0];
		else q_min_hold = val;
		reg_writes++;
	endtask

	// receiver: own stall pattern, plus a long counted hold-off on request
	int hold_left = 0;
	int pat_cnt = 0;
	int pat_kind = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			pat_cnt++;
			if (pat_cnt % 64 == 0) pat_kind = $urandom_range(0, 2);
			case (pat_kind)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= (pat_cnt % 4 == 0);
			endcase
		end
	end

	// result checker: each output transaction against the oldest expectation
	always @(posedge clk) begin : result_check
		qual_result_t got;
		qual_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.trig = m_axis_tdata[0];
			got.ticks = m_axis_tdata[11:1];
			got.phase = m_axis_tdata[13:12];
			if (got.trig) triggers_seen++;
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: trig %0d ticks %0d phase %0d",
						got.trig, got.ticks, got.phase);
			end else begin
				want = awaited_results.pop_front();
				if (got.trig !== want.trig || got.ticks !== want.ticks
					|| got.phase !== want.phase) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result mismatch: expected trig %0d ticks %0d phase %0d, got trig %0d ticks %0d phase %0d",
							want.trig, want.ticks, want.phase, got.trig, got.ticks, got.phase);
				end
			end
		end
	end

	// run limit
	initial begin
		#(LIMIT_CYCLES * 12);
		$display("[ttl_trigger_pulse_qualifier_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		int   n;
		int   k;
		int   len;
		logic idle_lvl;
		// reset asserted from time zero, released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			case (DIR_ROWS[i].kind)
				ROW_SAMPLE: send_sample(DIR_ROWS[i].arg[0], DIR_ROWS[i].fixed_exp, DIR_ROWS[i].want);
				ROW_SET_MODE: begin
					wait_drained();
					write_register(ttpq_pkg::REG_MODE, DIR_ROWS[i].arg);
				end
				default: begin
					wait_drained();
					write_register(ttpq_pkg::REG_MIN_ACT, DIR_ROWS[i].arg);
				end
			endcase
		end

		// random phases: mostly well-formed pulses, some noise and short idle runs
		for (int p = 0; p < N_RND; p++) begin
			wait_drained();
			write_register(ttpq_pkg::REG_MODE, count_t'(RND_MODES[p]));
			write_register(ttpq_pkg::REG_MIN_ACT, RND_MINS[p]);
			idle_lvl = (q_mode == ttpq_pkg::MODE_HIGH) ? 1'b0 : 1'b1;
			// long receiver hold-off while the sender keeps offering
			if (p == 1 || p == 4) hold_req = 1'b1;
			n = 0;
			while (n < 65) begin
				k = $urandom_range(0, 9);
				if (k < 7) begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 13);
					send_run(idle_lvl, len);
					n += len;
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
					send_run(~idle_lvl, len);
					n += len + 1;
					send_run(idle_lvl, 1);
				end else begin
					// sender pause until every result is back, now and then
					if (k == 9) wait_drained();
					len = $urandom_range(1, 6);
					repeat (len) send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
					n += len;
				end
			end
		end

		// drain, then allow for the two register stages
		wait_drained();
		repeat (4) @(posedge clk);
		$display("covered %0d line samples and %0d register writes over all modes,", samples_sent, reg_writes);
		$display("%0d triggers seen, with frozen, mode 3 and never-met hold cases", triggers_seen);
		if (fail_count == 0 && awaited_results.size() == 0) begin
			$display("[ttl_trigger_pulse_qualifier_top] OK");
		end else begin
			$display("[ttl_trigger_pulse_qualifier_top] ERROR");
		end
		$finish;
	end

endmodule
